FILE: sv/ttc_eb_pkg.sv
// Shared types and constants for the time-to-collision braking block.
`timescale 1ns / 1ps
package ttc_eb_pkg;

  localparam int unsigned MAX_BEAMS_DEF = 4096;
  localparam int unsigned COS_DEPTH_DEF = 1024;

  localparam int unsigned BEAM_W      = 12;
  localparam int unsigned ANGLE_W     = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register stages inside the cosine unit
  localparam int unsigned COS_LAT = 11;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TTC_LIMIT   = 3'd4;

  // input commands
  localparam logic CMD_SPEED = 1'b0;
  localparam logic CMD_RANGE = 1'b1;

  typedef struct packed {
    logic               test;
    logic               last;
    logic [BEAM_W-1:0]  beam;
    logic signed [15:0] speed;
    logic [15:0]        range_mm;
  } meta_t;

  typedef struct packed {
    meta_t              meta;
    logic [ANGLE_W-1:0] angle;
  } qent_t;

endpackage

FILE: sv/ttc_eb_front.sv
// Front end: config registers, speed tracking, beam indexing and range gating.
`timescale 1ns / 1ps
module ttc_eb_front #(
  parameter int unsigned MAX_BEAMS = ttc_eb_pkg::MAX_BEAMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cmd_i,
  input  logic signed [15:0]               speed_mm_s_i,
  input  logic [15:0]                      distance_mm_i,
  input  logic                             last_in_scan_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ttc_eb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output ttc_eb_pkg::qent_t                q_entry_o,
  output logic [15:0]                      ttc_limit_o
);
  import ttc_eb_pkg::*;

  localparam int unsigned BW = $clog2(MAX_BEAMS + 1);

  logic [15:0] angle_start_q, angle_start_d;
  logic [15:0] angle_step_q, angle_step_d;
  logic [15:0] range_low_q, range_low_d;
  logic [15:0] range_high_q, range_high_d;
  logic [15:0] ttc_limit_q, ttc_limit_d;
  logic signed [15:0] speed_q, speed_d;
  logic [BW-1:0] beam_cnt_q, beam_cnt_d;
  logic [ANGLE_W-1:0] run_angle_q, run_angle_d;

  logic accept, is_range, in_scan, in_win, test;
  logic [ANGLE_W-1:0] start_ext, step_ext, beam_angle;
  logic [BW+BEAM_W-1:0] beam_wide;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign ttc_limit_o = ttc_limit_q;

  always_comb begin
    accept     = in_valid_i && !q_full_i;
    is_range   = (cmd_i == CMD_RANGE);
    in_scan    = (beam_cnt_q < BW'(MAX_BEAMS));
    start_ext  = {{16{angle_start_q[15]}}, angle_start_q};
    step_ext   = {{16{angle_step_q[15]}}, angle_step_q};
    // beam 0 picks up angle_start as it stands now
    beam_angle = (beam_cnt_q == '0) ? start_ext : run_angle_q;
    in_win     = (distance_mm_i >= range_low_q) && (distance_mm_i <= range_high_q);
    test       = in_scan && in_win;
    beam_wide  = (BW + BEAM_W)'(beam_cnt_q);

    q_push_o                = accept && is_range && (test || last_in_scan_i);
    q_entry_o.meta.test     = test;
    q_entry_o.meta.last     = last_in_scan_i;
    q_entry_o.meta.beam     = beam_wide[BEAM_W-1:0];
    q_entry_o.meta.speed    = speed_q;
    q_entry_o.meta.range_mm = distance_mm_i;
    q_entry_o.angle         = beam_angle;
  end

  always_comb begin
    angle_start_d = angle_start_q;
    angle_step_d  = angle_step_q;
    range_low_d   = range_low_q;
    range_high_d  = range_high_q;
    ttc_limit_d   = ttc_limit_q;
    speed_d       = speed_q;
    beam_cnt_d    = beam_cnt_q;
    run_angle_d   = run_angle_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ANGLE_START: angle_start_d = cfg_data_i;
        CFG_ANGLE_STEP:  angle_step_d  = cfg_data_i;
        CFG_RANGE_LOW:   range_low_d   = cfg_data_i;
        CFG_RANGE_HIGH:  range_high_d  = cfg_data_i;
        CFG_TTC_LIMIT:   ttc_limit_d   = cfg_data_i;
        default: ;
      endcase
    end

    if (accept) begin
      if (cmd_i == CMD_SPEED) begin
        speed_d = speed_mm_s_i;
      end else begin
        // beams past the scan limit keep neither index nor angle
        if (in_scan) begin
          run_angle_d = beam_angle + step_ext;
          beam_cnt_d  = beam_cnt_q + BW'(1);
        end
        if (last_in_scan_i) begin
          beam_cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_start_q <= 16'd0;
      angle_step_q  <= 16'd0;
      range_low_q   <= 16'd0;
      range_high_q  <= 16'hFFFF;
      ttc_limit_q   <= 16'd1000;
      speed_q       <= 16'sd0;
      beam_cnt_q    <= '0;
      run_angle_q   <= '0;
    end else begin
      angle_start_q <= angle_start_d;
      angle_step_q  <= angle_step_d;
      range_low_q   <= range_low_d;
      range_high_q  <= range_high_d;
      ttc_limit_q   <= ttc_limit_d;
      speed_q       <= speed_d;
      beam_cnt_q    <= beam_cnt_d;
      run_angle_q   <= run_angle_d;
    end
  end

endmodule

FILE: sv/ttc_eb_fifo.sv
// Short queue between the front end and the back end.
`timescale 1ns / 1ps
module ttc_eb_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ttc_eb_pkg::qent_t entry_i,
  input  logic              pop_i,
  output ttc_eb_pkg::qent_t entry_o,
  output logic              valid_o,
  output logic              full_o
);
  import ttc_eb_pkg::*;

  qent_t mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: sv/ttc_eb_cos.sv
// Pipelined Q14 cosine: angle to phase, quarter-wave index, odd sine polynomial.
`timescale 1ns / 1ps
module ttc_eb_cos #(
  parameter int unsigned COS_TABLE_DEPTH = ttc_eb_pkg::COS_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [ttc_eb_pkg::ANGLE_W-1:0] angle_i,
  output logic signed [15:0]             cos_o
);
  import ttc_eb_pkg::*;

  localparam int unsigned DW  = $clog2(COS_TABLE_DEPTH + 1);
  localparam int unsigned XW  = 2 * DW;
  // t = m * 2^30 / D split as m*Q + floor(m*R / D)
  localparam longint unsigned QV  = (64'd1 << 30) / COS_TABLE_DEPTH;
  localparam longint unsigned RV  = (64'd1 << 30) % COS_TABLE_DEPTH;
  localparam longint unsigned RC  = (64'd1 << XW) / COS_TABLE_DEPTH;
  localparam int unsigned     RCW = $clog2(RC + 1);

  localparam logic [16:0] PHASE_PER_UNIT = 17'd83443;
  localparam logic [29:0] Q30_HALF       = 30'h2000_0000;
  localparam logic [30:0] K9 = 31'd172273;
  localparam logic [30:0] KC [4] = '{31'd5026994, 31'd85569306, 31'd693598672,
                                     31'd1686629713};

  // stage 0..4: phase, index, reciprocal split, quotient, t
  logic [31:0]    phase_q, phase_d;
  logic [29+DW:0] kprod;
  logic [DW-1:0]  k, m_q, m_d;
  logic           neg1_q, neg1_d, neg2_q, neg3_q, neg4_q, neg5_q;
  logic [XW-1:0]  x_q, x_d, x3_q;
  logic [30:0]    mq_q, mq_d, mq3_q;
  logic [XW+RCW-1:0] rc_prod;
  logic [DW-1:0]  q0_q, q0_d, q_fix;
  logic [XW-1:0]  qd, rem;
  logic [30:0]    t_q, t_d, t5_q;
  logic [61:0]    tt;
  logic [30:0]    t2_q, t2_d;
  logic [48:0]    ph_full;

  // Horner stages
  logic [30:0] p_q [4];
  logic [30:0] p_d [4];
  logic [30:0] th_q [4];
  logic [30:0] t2h_q [4];
  logic        negh_q [4];
  logic [61:0] hp [4];
  logic [31:0] hsub [4];
  logic [30:0] p_in [4];
  logic [30:0] t2_in [4];

  // output stage
  logic [61:0] sp;
  logic [32:0] sr;
  logic [16:0] sh;
  logic [14:0] mag;
  logic signed [15:0] cos_q, cos_d;

  assign cos_o = cos_q;

  always_comb begin
    ph_full = 49'(angle_i) * 49'(PHASE_PER_UNIT);
    phase_d = ph_full[31:0];

    kprod = (30 + DW)'(phase_q[29:0]) * (30 + DW)'(COS_TABLE_DEPTH)
          + (30 + DW)'(Q30_HALF);
    k     = kprod[29+DW:30];
    // even quadrants read the mirrored entry
    m_d    = phase_q[30] ? k : DW'(COS_TABLE_DEPTH) - k;
    neg1_d = phase_q[31] ^ phase_q[30];

    x_d  = XW'(m_q) * XW'(RV);
    mq_d = 31'(m_q) * 31'(QV);

    rc_prod = (XW + RCW)'(x_q) * (XW + RCW)'(RC);
    q0_d    = DW'(rc_prod >> XW);

    // estimate is at most one low
    qd    = XW'(q0_q) * XW'(COS_TABLE_DEPTH);
    rem   = x3_q - qd;
    q_fix = q0_q + DW'(rem >= XW'(COS_TABLE_DEPTH));
    t_d   = mq3_q + 31'(q_fix);

    tt   = 62'(t_q) * 62'(t_q);
    t2_d = tt[60:30];

    for (int j = 0; j < 4; j++) begin
      p_in[j]  = (j == 0) ? K9 : p_q[(j == 0) ? 0 : j - 1];
      t2_in[j] = (j == 0) ? t2_q : t2h_q[(j == 0) ? 0 : j - 1];
      hp[j]    = 62'(t2_in[j]) * 62'(p_in[j]);
      hsub[j]  = {1'b0, KC[j]} - hp[j][61:30];
      p_d[j]   = hsub[j][30:0];
    end

    sp  = 62'(th_q[3]) * 62'(p_q[3]);
    sr  = 33'(sp[61:30]) + 33'd32768;
    sh  = sr[32:16];
    mag = (sh > 17'd16384) ? 15'd16384 : sh[14:0];
    cos_d = negh_q[3] ? (16'sd0 - $signed({1'b0, mag})) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_q <= phase_d;
      m_q     <= m_d;
      neg1_q  <= neg1_d;
      x_q     <= x_d;
      mq_q    <= mq_d;
      neg2_q  <= neg1_q;
      q0_q    <= q0_d;
      x3_q    <= x_q;
      mq3_q   <= mq_q;
      neg3_q  <= neg2_q;
      t_q     <= t_d;
      neg4_q  <= neg3_q;
      t2_q    <= t2_d;
      t5_q    <= t_q;
      neg5_q  <= neg4_q;
      for (int j = 0; j < 4; j++) begin
        p_q[j]    <= p_d[j];
        t2h_q[j]  <= t2_in[j];
        th_q[j]   <= (j == 0) ? t5_q : th_q[(j == 0) ? 0 : j - 1];
        negh_q[j] <= (j == 0) ? neg5_q : negh_q[(j == 0) ? 0 : j - 1];
      end
      cos_q <= cos_d;
    end
  end

endmodule

FILE: sv/ttc_eb_back.sv
// Back end: closing speed, time-to-collision compare, first-hit tracking, result register.
`timescale 1ns / 1ps
module ttc_eb_back #(
  parameter int unsigned COS_TABLE_DEPTH = ttc_eb_pkg::COS_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  ttc_eb_pkg::qent_t             q_entry_i,
  output logic                          q_pop_o,
  input  logic [15:0]                   ttc_limit_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          brake_o,
  output logic [ttc_eb_pkg::BEAM_W-1:0] trigger_beam_o
);
  import ttc_eb_pkg::*;

  // distance in mm times 1000 ms/s times 2^14
  localparam logic [23:0] DIST_SCALE = 24'd16384000;

  logic en;
  logic signed [15:0] cos_w;

  logic  vld_q [COS_LAT];
  meta_t meta_q [COS_LAT];

  logic  vld_v_q;
  meta_t meta_v_q;
  logic signed [31:0] v_q, v_d;

  logic vld_c_q, last_c_q, hit_c_q, hit_c_d;
  logic [BEAM_W-1:0] beam_c_q;
  logic pos;
  logic [46:0] lhs, rhs;

  logic hit_seen_q, hit_seen_d;
  logic [BEAM_W-1:0] hit_beam_q, hit_beam_d;
  logic hit_now, seen_n;
  logic [BEAM_W-1:0] beam_n;
  logic out_valid_q, out_valid_d;
  logic brake_q, brake_d;
  logic [BEAM_W-1:0] trig_q, trig_d;

  // whole pipeline advances unless a finished result is held
  assign en          = !out_valid_q || !out_stall_i;
  assign q_pop_o     = en && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign brake_o     = brake_q;
  assign trigger_beam_o = trig_q;

  ttc_eb_cos #(
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
  ) u_cos (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(q_entry_i.angle),
    .cos_o  (cos_w)
  );

  always_comb begin
    v_d = meta_q[COS_LAT-1].speed * cos_w;

    pos     = !v_q[31] && (v_q != 32'sd0);
    rhs     = 47'(ttc_limit_i) * 47'(v_q[30:0]);
    lhs     = 47'(meta_v_q.range_mm) * 47'(DIST_SCALE);
    hit_c_d = meta_v_q.test && pos && (lhs < rhs);

    hit_now = vld_c_q && hit_c_q && !hit_seen_q;
    seen_n  = hit_seen_q || hit_now;
    beam_n  = hit_now ? beam_c_q : hit_beam_q;

    hit_seen_d  = hit_seen_q;
    hit_beam_d  = hit_beam_q;
    out_valid_d = out_valid_q;
    brake_d     = brake_q;
    trig_d      = trig_q;
    if (en) begin
      out_valid_d = vld_c_q && last_c_q;
      if (vld_c_q) begin
        if (last_c_q) begin
          brake_d    = seen_n;
          trig_d     = seen_n ? beam_n : '0;
          hit_seen_d = 1'b0;
          hit_beam_d = '0;
        end else begin
          hit_seen_d = seen_n;
          hit_beam_d = beam_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COS_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
      vld_v_q     <= 1'b0;
      vld_c_q     <= 1'b0;
      hit_seen_q  <= 1'b0;
      hit_beam_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q[0] <= q_pop_o;
        for (int i = 1; i < COS_LAT; i++) begin
          vld_q[i] <= vld_q[i-1];
        end
        vld_v_q <= vld_q[COS_LAT-1];
        vld_c_q <= vld_v_q;
      end
      hit_seen_q  <= hit_seen_d;
      hit_beam_q  <= hit_beam_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= q_entry_i.meta;
      for (int i = 1; i < COS_LAT; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
      meta_v_q <= meta_q[COS_LAT-1];
      v_q      <= v_d;
      last_c_q <= meta_v_q.last;
      beam_c_q <= meta_v_q.beam;
      hit_c_q  <= hit_c_d;
    end
    brake_q <= brake_d;
    trig_q  <= trig_d;
  end

endmodule

FILE: sv/ttc_emergency_brake_core.sv
// Top level of the time-to-collision emergency braking block.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o     | cmd_i, speed_mm_s_i, distance_mm_i, last_in_scan_i
//  out     | out_valid_o / out_stall_i   | brake_o, trigger_beam_o
//  cfg     | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
//  One input transaction per cycle while the 4-entry queue has room; the back end
//  pipeline (11-stage cosine, multiply, compare) also takes one entry per cycle unless a
//  result is held. A closing sample passes the queue and these stages to the result register.
//  Reset clears control state and loads the register defaults; no clearing pass.
//  A held result freezes the back end; the front keeps accepting until the queue fills.
`timescale 1ns / 1ps
module ttc_emergency_brake_core #(
  parameter int unsigned MAX_BEAMS       = ttc_eb_pkg::MAX_BEAMS_DEF,
  parameter int unsigned COS_TABLE_DEPTH = ttc_eb_pkg::COS_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cmd_i,
  input  logic signed [15:0]               speed_mm_s_i,
  input  logic [15:0]                      distance_mm_i,
  input  logic                             last_in_scan_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             brake_o,
  output logic [ttc_eb_pkg::BEAM_W-1:0]    trigger_beam_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ttc_eb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                      cfg_data_i
);
  import ttc_eb_pkg::*;

  qent_t push_entry, head_entry;
  logic  q_push, q_pop, q_valid, q_full;
  logic [15:0] ttc_limit;

  ttc_eb_front #(
    .MAX_BEAMS(MAX_BEAMS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .speed_mm_s_i  (speed_mm_s_i),
    .distance_mm_i (distance_mm_i),
    .last_in_scan_i(last_in_scan_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry),
    .ttc_limit_o   (ttc_limit)
  );

  ttc_eb_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(push_entry),
    .pop_i  (q_pop),
    .entry_o(head_entry),
    .valid_o(q_valid),
    .full_o (q_full)
  );

  ttc_eb_back #(
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (head_entry),
    .q_pop_o       (q_pop),
    .ttc_limit_i   (ttc_limit),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .brake_o       (brake_o),
    .trigger_beam_o(trigger_beam_o)
  );

endmodule

FILE: sv/ttc_eb_checker.sv
// Port-level assertions for the braking block, bound to the top level.
`timescale 1ns / 1ps
module ttc_eb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             cmd_i,
  input logic                             last_in_scan_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             brake_o,
  input logic [ttc_eb_pkg::BEAM_W-1:0]    trigger_beam_o
);
  import ttc_eb_pkg::*;

  logic [7:0] pend_q, pend_d;
  logic in_close, out_take;

  // closing samples accepted but not yet answered
  always_comb begin
    in_close = in_valid_i && !in_stall_o && cmd_i && last_in_scan_i;
    out_take = out_valid_o && !out_stall_i;
    pend_d   = pend_q + 8'(in_close) - 8'(out_take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_result_has_cause: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 8'd0)
  ) else $error("result without an outstanding closing sample");

  a_no_brake_no_beam: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !brake_o) |-> (trigger_beam_o == '0)
  ) else $error("beam index reported without brake");

  a_held_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(brake_o) && $stable(trigger_beam_o))
  ) else $error("stalled result changed");

endmodule

bind ttc_emergency_brake_core ttc_eb_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .cmd_i         (cmd_i),
  .last_in_scan_i(last_in_scan_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .brake_o       (brake_o),
  .trigger_beam_o(trigger_beam_o)
);
